// ----- design/cdc_pkg.sv -----
package cdc_pkg;

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_NEXT = 2'd1,
        CMD_PREV = 2'd2,
        CMD_DIFF = 2'd3
    } t_cmd;

    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2000;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_MAR  = 4'd3;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [4:0]  DAY_LAST   = 5'd31;

    localparam int          DN_W          = 22;
    localparam logic [21:0] DAYS_PER_YEAR = 22'd365;
    localparam logic [21:0] DN_REF        = 22'd730426;

    localparam int          PROD_W      = 25;
    localparam int          QUO_W       = 8;
    localparam int          RECIP_SHIFT = 17;
    localparam logic [24:0] RECIP_25    = 25'd5243;
    localparam logic [11:0] DIV_25      = 12'd25;
    localparam logic [6:0]  MOD100_LAST = 7'd99;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [13:0] in_year;
    } t_req;

    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [13:0] cur_year;
        logic        set_ok;
        logic        range_error;
        logic [21:0] day_difference;
    } t_rsp;

    typedef struct packed {
        t_req        req;
        logic [21:0] day_num;
        logic        date_ok;
        logic [6:0]  mod100;
        logic [1:0]  cent_mod4;
    } t_prep;

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Days from the start of a March-based year to the first of the month.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] off;
        case (m)
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// ----- design/cdc_stream_if.sv -----
interface cdc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/cdc_prep_pipe.sv -----
module cdc_prep_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cdc_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output cdc_pkg::t_prep o_prep
);

    logic go1, go2, go3, go4;

    logic                              r1_v;
    cdc_pkg::t_req                     r1_req;

    logic                              r2_v;
    cdc_pkg::t_req                     r2_req;
    logic [13:0]                       r2_yp;
    logic [cdc_pkg::PROD_W-1:0]        r2_prod_p;
    logic [cdc_pkg::PROD_W-1:0]        r2_prod_y;

    logic                              r3_v;
    cdc_pkg::t_req                     r3_req;
    logic [cdc_pkg::DN_W-1:0]          r3_yp365;
    logic [11:0]                       r3_lc;
    logic                              r3_leap;
    logic [6:0]                        r3_mod100;
    logic [1:0]                        r3_c4;

    logic                              r4_v;
    cdc_pkg::t_prep                    r4_prep;

    logic [13:0]                       n2_yp;
    logic [cdc_pkg::PROD_W-1:0]        n2_prod_p;
    logic [cdc_pkg::PROD_W-1:0]        n2_prod_y;

    logic [cdc_pkg::QUO_W-1:0]         c100p;
    logic [cdc_pkg::QUO_W-1:0]         c100y;
    logic [11:0]                       rem25;
    logic [cdc_pkg::DN_W-1:0]          n3_yp365;
    logic [11:0]                       n3_lc;
    logic                              n3_leap;
    logic [6:0]                        n3_mod100;

    cdc_pkg::t_prep                    n4_prep;

    assign go4     = !r4_v || i_ready;
    assign go3     = !r3_v || go4;
    assign go2     = !r2_v || go3;
    assign go1     = !r1_v || go2;
    assign o_ready = go1;
    assign o_valid = r4_v;
    assign o_prep  = r4_prep;

    // January and February belong to the year before in the day count.
    always_comb begin
        n2_yp     = (r1_req.in_month < cdc_pkg::MONTH_MAR) ? r1_req.in_year - 14'd1
                                                           : r1_req.in_year;
        n2_prod_p = cdc_pkg::PROD_W'(n2_yp[13:2]) * cdc_pkg::RECIP_25;
        n2_prod_y = cdc_pkg::PROD_W'(r1_req.in_year[13:2]) * cdc_pkg::RECIP_25;
    end

    always_comb begin
        c100p     = r2_prod_p[cdc_pkg::RECIP_SHIFT +: cdc_pkg::QUO_W];
        c100y     = r2_prod_y[cdc_pkg::RECIP_SHIFT +: cdc_pkg::QUO_W];
        n3_yp365  = cdc_pkg::DN_W'(r2_yp) * cdc_pkg::DAYS_PER_YEAR;
        n3_lc     = r2_yp[13:2] - 12'(c100p) + 12'(c100p[cdc_pkg::QUO_W-1:2]);
        rem25     = r2_req.in_year[13:2] - 12'(c100y) * cdc_pkg::DIV_25;
        n3_mod100 = {rem25[4:0], r2_req.in_year[1:0]};
        n3_leap   = (r2_req.in_year[1:0] == 2'd0) &&
                    ((rem25[4:0] != 5'd0) || (c100y[1:0] == 2'd0));
    end

    always_comb begin
        n4_prep.req       = r3_req;
        n4_prep.day_num   = r3_yp365 + cdc_pkg::DN_W'(r3_lc)
                          + cdc_pkg::DN_W'(cdc_pkg::month_offset(r3_req.in_month))
                          + cdc_pkg::DN_W'(r3_req.in_day);
        n4_prep.date_ok   = (r3_req.in_year >= cdc_pkg::YEAR_MIN) &&
                            (r3_req.in_year <= cdc_pkg::YEAR_MAX) &&
                            (r3_req.in_month >= cdc_pkg::MONTH_JAN) &&
                            (r3_req.in_month <= cdc_pkg::MONTH_DEC) &&
                            (r3_req.in_day >= cdc_pkg::DAY_FIRST) &&
                            (r3_req.in_day <= cdc_pkg::month_length(r3_req.in_month,
                                                                     r3_leap));
        n4_prep.mod100    = r3_mod100;
        n4_prep.cent_mod4 = r3_c4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (go1) r1_v <= i_valid;
            if (go2) r2_v <= r1_v;
            if (go3) r3_v <= r2_v;
            if (go4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go1) begin
            r1_req <= i_req;
        end
        if (go2) begin
            r2_req    <= r1_req;
            r2_yp     <= n2_yp;
            r2_prod_p <= n2_prod_p;
            r2_prod_y <= n2_prod_y;
        end
        if (go3) begin
            r3_req    <= r2_req;
            r3_yp365  <= n3_yp365;
            r3_lc     <= n3_lc;
            r3_leap   <= n3_leap;
            r3_mod100 <= n3_mod100;
            r3_c4     <= c100y[1:0];
        end
        if (go4) begin
            r4_prep <= n4_prep;
        end
    end

endmodule

// ----- design/calendar_date_counter_unit.sv -----
// Channel  Dir  Modport  Payload  Contents
// i_req    in   sink     t_req    command, in_month, in_day, in_year
// o_rsp    out  source   t_rsp    stored date, set_ok, range_error, day_difference
//
// One request is taken per cycle unless back-pressure on o_rsp fills the pipeline; responses leave in request order.
// Four stages prepare the day number of the given date, and the stored date is updated
// as a request enters the output register, so requests follow back to back.
// Reset restores 1 January 2000 and empties the pipeline.
// Each stage holds its request only while the next one is full and stalled.
module calendar_date_counter_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cdc_stream_if.sink   i_req,
    cdc_stream_if.source o_rsp
);

    logic           prep_v;
    logic           go5;
    cdc_pkg::t_prep prep;
    cdc_pkg::t_req  req_in;

    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [13:0] r_year, n_year;
    logic [21:0] r_dn, n_dn;
    logic [6:0]  r_mod100, n_mod100;
    logic [1:0]  r_c4, n_c4;

    logic          r_out_v;
    cdc_pkg::t_rsp r_rsp, n_rsp;

    logic        cur_leap;
    logic [4:0]  cur_len;
    logic [21:0] ref_dn;

    assign req_in = i_req.payload;

    cdc_prep_pipe u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_req   (req_in),
        .o_valid (prep_v),
        .i_ready (go5),
        .o_prep  (prep)
    );

    assign go5           = !r_out_v || o_rsp.ready;
    assign o_rsp.valid   = r_out_v;
    assign o_rsp.payload = r_rsp;

    assign cur_leap = (r_year[1:0] == 2'd0) && ((r_mod100 != 7'd0) || (r_c4 == 2'd0));
    assign cur_len  = cdc_pkg::month_length(r_month, cur_leap);
    assign ref_dn   = prep.date_ok ? prep.day_num : cdc_pkg::DN_REF;

    always_comb begin
        n_month  = r_month;
        n_day    = r_day;
        n_year   = r_year;
        n_dn     = r_dn;
        n_mod100 = r_mod100;
        n_c4     = r_c4;
        n_rsp.set_ok         = 1'b0;
        n_rsp.range_error    = 1'b0;
        n_rsp.day_difference = 22'd0;
        unique case (prep.req.command)
            cdc_pkg::CMD_SET: begin
                if (prep.date_ok) begin
                    n_month      = prep.req.in_month;
                    n_day        = prep.req.in_day;
                    n_year       = prep.req.in_year;
                    n_dn         = prep.day_num;
                    n_mod100     = prep.mod100;
                    n_c4         = prep.cent_mod4;
                    n_rsp.set_ok = 1'b1;
                end
            end
            cdc_pkg::CMD_NEXT: begin
                if (r_month == cdc_pkg::MONTH_DEC && r_day == cdc_pkg::DAY_LAST &&
                    r_year >= cdc_pkg::YEAR_MAX) begin
                    n_rsp.range_error = 1'b1;
                end else begin
                    n_dn = r_dn + 22'd1;
                    if (r_day >= cur_len) begin
                        n_day = cdc_pkg::DAY_FIRST;
                        if (r_month >= cdc_pkg::MONTH_DEC) begin
                            n_month = cdc_pkg::MONTH_JAN;
                            n_year  = r_year + 14'd1;
                            if (r_mod100 == cdc_pkg::MOD100_LAST) begin
                                n_mod100 = 7'd0;
                                n_c4     = r_c4 + 2'd1;
                            end else begin
                                n_mod100 = r_mod100 + 7'd1;
                            end
                        end else begin
                            n_month = r_month + 4'd1;
                        end
                    end else begin
                        n_day = r_day + 5'd1;
                    end
                end
            end
            cdc_pkg::CMD_PREV: begin
                if (r_month == cdc_pkg::MONTH_JAN && r_day == cdc_pkg::DAY_FIRST &&
                    r_year <= cdc_pkg::YEAR_MIN) begin
                    n_rsp.range_error = 1'b1;
                end else begin
                    n_dn = r_dn - 22'd1;
                    if (r_day <= cdc_pkg::DAY_FIRST) begin
                        if (r_month <= cdc_pkg::MONTH_JAN) begin
                            n_month = cdc_pkg::MONTH_DEC;
                            n_day   = cdc_pkg::DAY_LAST;
                            n_year  = r_year - 14'd1;
                            if (r_mod100 == 7'd0) begin
                                n_mod100 = cdc_pkg::MOD100_LAST;
                                n_c4     = r_c4 - 2'd1;
                            end else begin
                                n_mod100 = r_mod100 - 7'd1;
                            end
                        end else begin
                            n_month = r_month - 4'd1;
                            n_day   = cdc_pkg::month_length(r_month - 4'd1, cur_leap);
                        end
                    end else begin
                        n_day = r_day - 5'd1;
                    end
                end
            end
            cdc_pkg::CMD_DIFF: begin
                n_rsp.day_difference = (r_dn >= ref_dn) ? r_dn - ref_dn : ref_dn - r_dn;
            end
            default: begin
            end
        endcase
        n_rsp.cur_month = n_month;
        n_rsp.cur_day   = n_day;
        n_rsp.cur_year  = n_year;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_month  <= cdc_pkg::MONTH_JAN;
            r_day    <= cdc_pkg::DAY_FIRST;
            r_year   <= cdc_pkg::YEAR_RESET;
            r_dn     <= cdc_pkg::DN_REF;
            r_mod100 <= 7'd0;
            r_c4     <= 2'd0;
        end else if (go5) begin
            r_out_v <= prep_v;
            if (prep_v) begin
                r_month  <= n_month;
                r_day    <= n_day;
                r_year   <= n_year;
                r_dn     <= n_dn;
                r_mod100 <= n_mod100;
                r_c4     <= n_c4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go5 && prep_v) begin
            r_rsp <= n_rsp;
        end
    end

    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_month >= cdc_pkg::MONTH_JAN) &&
                           (r_month <= cdc_pkg::MONTH_DEC) &&
                           (r_day >= cdc_pkg::DAY_FIRST) && (r_day <= cur_len))
        else $error("stored date is not a valid calendar date");

    a_mod100_tracks_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_mod100[1:0] == r_year[1:0]) &&
                           (r_mod100 <= cdc_pkg::MOD100_LAST))
        else $error("year-within-century counter out of step with the year");

    a_next_day_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go5 && prep_v && prep.req.command == cdc_pkg::CMD_NEXT && !n_rsp.range_error)
        |=> (r_dn == $past(r_dn) + 22'd1))
        else $error("day number did not advance with the date");

    a_rsp_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_rsp.set_ok && r_rsp.range_error))
        else $error("response carries both set_ok and range_error");

endmodule

// ----- verif/tb_calendar_date_counter_unit.sv -----
module tb_calendar_date_counter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cdc_stream_if #(.T(cdc_pkg::t_req)) req_if ();
    cdc_stream_if #(.T(cdc_pkg::t_rsp)) rsp_if ();

    calendar_date_counter_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    cdc_pkg::t_req pending_requests[$];
    cdc_pkg::t_rsp expected_responses[$];

    logic [3:0]  cal_month = cdc_pkg::MONTH_JAN;
    logic [4:0]  cal_day   = cdc_pkg::DAY_FIRST;
    logic [13:0] cal_year  = cdc_pkg::YEAR_RESET;

    logic req_taken = 1'b0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   mismatch_count = 0;
    int   phase_items = 0;

    always #2 i_clk = ~i_clk;

    function automatic bit is_leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 2) begin
            return is_leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic bit is_valid_date(input int m, input int d, input int y);
        if (y < cdc_pkg::YEAR_MIN || y > cdc_pkg::YEAR_MAX ||
                m < cdc_pkg::MONTH_JAN || m > cdc_pkg::MONTH_DEC) begin
            return 1'b0;
        end
        return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // Days counted from a March-based year, so that the leap day ends the year.
    function automatic int day_index(input int m, input int d, input int y);
        int mm;
        int yy;
        mm = m;
        yy = y;
        if (mm < 3) begin
            yy = yy - 1;
            mm = mm + 12;
        end
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm - 457) / 5 + d - 306;
    endfunction

    function automatic cdc_pkg::t_rsp advance_calendar(input cdc_pkg::t_req r);
        cdc_pkg::t_rsp rsp;
        int   m;
        int   d;
        int   y;
        int   a;
        int   b;
        rsp = '0;
        m = r.in_month;
        d = r.in_day;
        y = r.in_year;
        case (r.command)
            cdc_pkg::CMD_SET: begin
                if (is_valid_date(m, d, y)) begin
                    cal_month = r.in_month;
                    cal_day = r.in_day;
                    cal_year = r.in_year;
                    rsp.set_ok = 1'b1;
                end
            end
            cdc_pkg::CMD_NEXT: begin
                if (cal_month == cdc_pkg::MONTH_DEC && cal_day == cdc_pkg::DAY_LAST &&
                        cal_year == cdc_pkg::YEAR_MAX) begin
                    rsp.range_error = 1'b1;
                end else if (cal_day >= days_in_month(cal_month, cal_year)) begin
                    cal_day = cdc_pkg::DAY_FIRST;
                    if (cal_month == cdc_pkg::MONTH_DEC) begin
                        cal_month = cdc_pkg::MONTH_JAN;
                        cal_year = cal_year + 14'd1;
                    end else begin
                        cal_month = cal_month + 4'd1;
                    end
                end else begin
                    cal_day = cal_day + 5'd1;
                end
            end
            cdc_pkg::CMD_PREV: begin
                if (cal_month == cdc_pkg::MONTH_JAN && cal_day == cdc_pkg::DAY_FIRST &&
                        cal_year == cdc_pkg::YEAR_MIN) begin
                    rsp.range_error = 1'b1;
                end else if (cal_day == cdc_pkg::DAY_FIRST) begin
                    if (cal_month == cdc_pkg::MONTH_JAN) begin
                        cal_month = cdc_pkg::MONTH_DEC;
                        cal_year = cal_year - 14'd1;
                    end else begin
                        cal_month = cal_month - 4'd1;
                    end
                    cal_day = 5'(days_in_month(cal_month, cal_year));
                end else begin
                    cal_day = cal_day - 5'd1;
                end
            end
            default: begin
                if (!is_valid_date(m, d, y)) begin
                    m = cdc_pkg::MONTH_JAN;
                    d = cdc_pkg::DAY_FIRST;
                    y = cdc_pkg::YEAR_RESET;
                end
                a = day_index(cal_month, cal_day, cal_year);
                b = day_index(m, d, y);
                rsp.day_difference = 22'((a >= b) ? (a - b) : (b - a));
            end
        endcase
        rsp.cur_month = cal_month;
        rsp.cur_day = cal_day;
        rsp.cur_year = cal_year;
        return rsp;
    endfunction

    function automatic cdc_pkg::t_req make_req(input cdc_pkg::t_cmd c, input int m,
                                               input int d, input int y);
        cdc_pkg::t_req r;
        r.command = c;
        r.in_month = 4'(m);
        r.in_day = 5'(d);
        r.in_year = 14'(y);
        return r;
    endfunction

    function automatic cdc_pkg::t_req random_valid_req(input cdc_pkg::t_cmd c);
        int y;
        int m;
        int len;
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: y = $urandom_range(1, 3);
            1: y = $urandom_range(9997, 9999);
            2: y = $urandom_range(1, 99) * 100;
            default: y = $urandom_range(1, 9999);
        endcase
        m = $urandom_range(1, 12);
        len = days_in_month(m, y);
        sel = $urandom_range(9);
        return make_req(c, m, (sel < 3) ? len : (sel < 5) ? 1 : $urandom_range(1, len), y);
    endfunction

    function automatic cdc_pkg::t_req random_noise_req(input cdc_pkg::t_cmd c);
        return make_req(c, $urandom_range(15), $urandom_range(31), $urandom_range(16383));
    endfunction

    task automatic enqueue_request(input cdc_pkg::t_req r);
        pending_requests.push_back(r);
        phase_items++;
    endtask

    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || req_if.valid ||
               expected_responses.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.payload <= pending_requests.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cdc_pkg::t_rsp exp_rsp;
        cdc_pkg::t_rsp got_rsp;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            expected_responses.push_back(advance_calendar(req_if.payload));
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_rsp = rsp_if.payload;
            if (expected_responses.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected response: %0d/%0d/%0d ok=%0b rerr=%0b diff=%0d",
                             got_rsp.cur_month, got_rsp.cur_day, got_rsp.cur_year,
                             got_rsp.set_ok, got_rsp.range_error, got_rsp.day_difference);
                end
                mismatch_count++;
            end else begin
                exp_rsp = expected_responses.pop_front();
                if (got_rsp.cur_month !== exp_rsp.cur_month || got_rsp.cur_day !== exp_rsp.cur_day
                        || got_rsp.cur_year !== exp_rsp.cur_year
                        || got_rsp.set_ok !== exp_rsp.set_ok
                        || got_rsp.range_error !== exp_rsp.range_error
                        || got_rsp.day_difference !== exp_rsp.day_difference) begin
                    if (mismatch_count < 10) begin
                        $write("%0t: expected %0d/%0d/%0d ok=%0b rerr=%0b diff=%0d,",
                               $realtime, exp_rsp.cur_month, exp_rsp.cur_day,
                               exp_rsp.cur_year, exp_rsp.set_ok, exp_rsp.range_error,
                               exp_rsp.day_difference);
                        $display(" got %0d/%0d/%0d ok=%0b rerr=%0b diff=%0d",
                                 got_rsp.cur_month, got_rsp.cur_day, got_rsp.cur_year,
                                 got_rsp.set_ok, got_rsp.range_error,
                                 got_rsp.day_difference);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("calendar_date_counter_unit: mismatch");
        $finish;
    end

    initial begin
        int   phase_idx;
        int   kind;
        int   steps;
        int   dir;
        int   k;
        cdc_pkg::t_req start_req;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Calendar limits, leap rules, month rollovers and rejected dates.
        enqueue_request(make_req(cdc_pkg::CMD_DIFF, 1, 1, 2000));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 12, 31, 9999));
        enqueue_request(make_req(cdc_pkg::CMD_NEXT, 15, 31, 16383));
        enqueue_request(make_req(cdc_pkg::CMD_PREV, 0, 0, 0));
        enqueue_request(make_req(cdc_pkg::CMD_NEXT, 0, 0, 0));
        enqueue_request(make_req(cdc_pkg::CMD_DIFF, 1, 1, 1));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 1, 1, 1));
        enqueue_request(make_req(cdc_pkg::CMD_PREV, 15, 31, 16383));
        enqueue_request(make_req(cdc_pkg::CMD_NEXT, 0, 0, 0));
        enqueue_request(make_req(cdc_pkg::CMD_PREV, 0, 0, 0));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 2, 29, 2000));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 2, 29, 1900));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 2, 29, 2024));
        enqueue_request(make_req(cdc_pkg::CMD_NEXT, 0, 0, 0));
        enqueue_request(make_req(cdc_pkg::CMD_PREV, 0, 0, 0));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 0, 10, 2000));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 13, 10, 2000));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 15, 31, 16383));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 4, 31, 2000));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 5, 0, 2000));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 6, 15, 0));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 6, 15, 10000));
        enqueue_request(make_req(cdc_pkg::CMD_DIFF, 2, 30, 2023));
        enqueue_request(make_req(cdc_pkg::CMD_SET, 12, 31, 1999));
        enqueue_request(make_req(cdc_pkg::CMD_NEXT, 0, 0, 0));
        enqueue_request(make_req(cdc_pkg::CMD_DIFF, 3, 1, 2100));
        wait_until_drained();

        for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
            case (phase_idx % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            endcase
            phase_items = 0;
            while (phase_items < 153) begin
                kind = $urandom_range(99);
                if (kind < 40) begin
                    // Load a date, often near a boundary, then step forward or back from it.
                    k = $urandom_range(5);
                    if (k == 0) begin
                        start_req = make_req(cdc_pkg::CMD_SET, 12, $urandom_range(28, 31),
                                             9999);
                    end else if (k == 1) begin
                        start_req = make_req(cdc_pkg::CMD_SET, 1, $urandom_range(1, 4), 1);
                    end else begin
                        start_req = random_valid_req(cdc_pkg::CMD_SET);
                    end
                    enqueue_request(start_req);
                    steps = $urandom_range(2, 8);
                    dir = $urandom_range(2);
                    for (k = 0; k < steps; k++) begin
                        if (dir == 0 || (dir == 2 && $urandom_range(1) == 0)) begin
                            enqueue_request(random_noise_req(cdc_pkg::CMD_NEXT));
                        end else begin
                            enqueue_request(random_noise_req(cdc_pkg::CMD_PREV));
                        end
                    end
                    if ($urandom_range(1) == 0) begin
                        enqueue_request(random_valid_req(cdc_pkg::CMD_DIFF));
                    end
                end else if (kind < 60) begin
                    enqueue_request(random_valid_req(cdc_pkg::CMD_DIFF));
                end else if (kind < 70) begin
                    enqueue_request(random_noise_req(cdc_pkg::CMD_DIFF));
                end else if (kind < 80) begin
                    enqueue_request(random_noise_req(cdc_pkg::CMD_SET));
                end else if (kind < 90) begin
                    enqueue_request(random_noise_req(cdc_pkg::CMD_NEXT));
                end else begin
                    enqueue_request(random_noise_req(cdc_pkg::CMD_PREV));
                end
            end
            wait_until_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_responses.size() == 0) begin
            $display("calendar_date_counter_unit: match");
        end else begin
            $display("calendar_date_counter_unit: mismatch");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/cdc_pkg.sv
design/cdc_stream_if.sv
design/cdc_prep_pipe.sv
design/calendar_date_counter_unit.sv
verif/tb_calendar_date_counter_unit.sv
